// ===== rtl/core/lts_pkg.sv =====
// lts_pkg: token codes, scanner modes, character classes and the result record
// shared by the scanner core, its result queue and the top level
// no dependencies
package lts_pkg;

	localparam int LINE_OUT_W = 16;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	// source characters with special meaning
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	typedef enum logic [4:0] {
		K_LEFT_PAREN    = 5'd0,
		K_RIGHT_PAREN   = 5'd1,
		K_LEFT_BRACE    = 5'd2,
		K_RIGHT_BRACE   = 5'd3,
		K_COMMA         = 5'd4,
		K_DOT           = 5'd5,
		K_MINUS         = 5'd6,
		K_PLUS          = 5'd7,
		K_SEMICOLON     = 5'd8,
		K_SLASH         = 5'd9,
		K_STAR          = 5'd10,
		K_BANG          = 5'd11,
		K_BANG_EQUAL    = 5'd12,
		K_EQUAL         = 5'd13,
		K_EQUAL_EQUAL   = 5'd14,
		K_GREATER       = 5'd15,
		K_GREATER_EQUAL = 5'd16,
		K_LESS          = 5'd17,
		K_LESS_EQUAL    = 5'd18,
		K_STRING        = 5'd19,
		K_NUMBER        = 5'd20,
		K_EOF           = 5'd21,
		K_UNEXPECTED    = 5'd22,
		K_UNTERMINATED  = 5'd23
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_STRING  = 2'd2,
		MODE_NUMBER  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_EQUAL   = 3'd1,
		OP_BANG    = 3'd2,
		OP_LESS    = 3'd3,
		OP_GREATER = 3'd4,
		OP_SLASH   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		CL_TOKEN,
		CL_OPER,
		CL_BLANK,
		CL_NEWLINE,
		CL_QUOTE,
		CL_DIGIT,
		CL_OTHER
	} cls_t;

	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              lexeme_char;
		logic                    has_char;
		logic                    has_dot;
		logic [LINE_OUT_W-1:0]   line;
		logic                    error_seen;
		logic                    last;
	} res_t;

	// up to two results written to the queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic cls_t char_class(input logic [7:0] c);
		cls_t cl;
		case (c) inside
			CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT,
			CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR:          cl = CL_TOKEN;
			CH_EQUAL, CH_BANG, CH_LESS, CH_GREATER, CH_SLASH: cl = CL_OPER;
			CH_SPACE, CH_TAB:                             cl = CL_BLANK;
			CH_NL:                                        cl = CL_NEWLINE;
			CH_QUOTE:                                     cl = CL_QUOTE;
			[CH_ZERO:CH_NINE]:                            cl = CL_DIGIT;
			default:                                      cl = CL_OTHER;
		endcase
		return cl;
	endfunction

	function automatic kind_t token_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_LPAREN: k = K_LEFT_PAREN;
			CH_RPAREN: k = K_RIGHT_PAREN;
			CH_LBRACE: k = K_LEFT_BRACE;
			CH_RBRACE: k = K_RIGHT_BRACE;
			CH_COMMA:  k = K_COMMA;
			CH_DOT:    k = K_DOT;
			CH_MINUS:  k = K_MINUS;
			CH_PLUS:   k = K_PLUS;
			CH_SEMI:   k = K_SEMICOLON;
			default:   k = K_STAR;
		endcase
		return k;
	endfunction

	function automatic op_t oper_of(input logic [7:0] c);
		op_t o;
		case (c)
			CH_EQUAL:   o = OP_EQUAL;
			CH_BANG:    o = OP_BANG;
			CH_LESS:    o = OP_LESS;
			CH_GREATER: o = OP_GREATER;
			default:    o = OP_SLASH;
		endcase
		return o;
	endfunction

	function automatic kind_t single_kind(input op_t o);
		kind_t k;
		case (o)
			OP_EQUAL:   k = K_EQUAL;
			OP_BANG:    k = K_BANG;
			OP_LESS:    k = K_LESS;
			OP_GREATER: k = K_GREATER;
			default:    k = K_SLASH;
		endcase
		return k;
	endfunction

	function automatic kind_t double_kind(input op_t o);
		kind_t k;
		case (o)
			OP_EQUAL: k = K_EQUAL_EQUAL;
			OP_BANG:  k = K_BANG_EQUAL;
			OP_LESS:  k = K_LESS_EQUAL;
			default:  k = K_GREATER_EQUAL;
		endcase
		return k;
	endfunction

	// line and error fields are filled in by the caller
	function automatic res_t mk_res(input kind_t k, input logic [7:0] c, input logic has,
			input logic flt, input logic lst);
		res_t r;
		r.kind        = k;
		r.lexeme_char = has ? c : 8'h00;
		r.has_char    = has;
		r.has_dot     = flt;
		r.line        = '0;
		r.error_seen  = 1'b0;
		r.last        = lst;
		return r;
	endfunction

	function automatic logic is_err_kind(input kind_t k);
		return (k == K_UNEXPECTED) || (k == K_UNTERMINATED);
	endfunction

endpackage

// ===== rtl/core/lexical_token_scanner_top.sv =====
// lexical_token_scanner_top: streaming source scanner, one character beat in,
// token result beats out; depends on lts_pkg, lts_scan and lts_out_queue
//
// Input channel: in_valid/in_ready with ch and end_of_input. Each beat carries
// one source byte, or an end-of-input mark that flushes any pending operator,
// open number or open string and then gives an eof result.
// Output channel: out_valid/out_ready with kind, lexeme_char, has_char,
// has_dot, line, error_seen and last. One input beat gives zero, one or two
// results; string and number characters come out as a run closed by a result
// with last set.
// Each result is written into the result queue as its input beat is taken.
// Throughput: one input beat per cycle while the output side keeps up; the
// output moves one result per cycle, so beats giving two results outrun it.
// The four-entry result queue sets this: in_ready is high while
// it holds at most two results.
// Reset: the queue is emptied, the line count returns to one, the error flag
// clears and scanning restarts in normal mode. An end-of-input beat restarts
// the scanner the same way but leaves queued results in place.
// A stalled receiver fills the queue and then holds in_ready low; nothing lost.
module lexical_token_scanner_top #(
	parameter int LINE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        ch,
	input  logic                              end_of_input,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [4:0]                        kind,
	output logic [7:0]                        lexeme_char,
	output logic                              has_char,
	output logic                              has_dot,
	output logic [lts_pkg::LINE_OUT_W-1:0]    line,
	output logic                              error_seen,
	output logic                              last
);
	import lts_pkg::*;

	logic  acc;
	push_t push;
	res_t  head;
	logic  room;

	assign in_ready = room;
	assign acc      = in_valid && room;

	lts_scan #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.ch           (ch),
		.end_of_input (end_of_input),
		.push         (push)
	);

	lts_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind        = head.kind;
	assign lexeme_char = head.lexeme_char;
	assign has_char    = head.has_char;
	assign has_dot     = head.has_dot;
	assign line        = head.line;
	assign error_seen  = head.error_seen;
	assign last        = head.last;

endmodule

// ===== rtl/core/lts_scan.sv =====
// lts_scan: scanner state (mode, pending operator, line count, error flag)
// and the single-pass logic that turns one character beat into up to two results
// depends on lts_pkg
module lts_scan #(
	parameter int LINE_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic [7:0]    ch,
	input  logic          end_of_input,
	output lts_pkg::push_t push
);
	import lts_pkg::*;

	mode_t                 mode_q, mode_d;
	op_t                   op_q, op_d;
	logic [LINE_WIDTH-1:0] line_q, line_d, line_inc;
	logic                  err_q, err_d;
	logic                  dot_q, dot_d;

	cls_t  cls;
	logic  sn_put;
	res_t  sn_res;
	res_t  r0, r1;
	logic [1:0] n;
	logic  err0, err1;
	logic [LINE_OUT_W-1:0] line_out;

	assign cls      = char_class(ch);
	assign line_inc = (line_q == {LINE_WIDTH{1'b1}}) ? line_q : line_q + 1'b1;
	assign line_out = LINE_OUT_W'(line_q);

	// result of scanning a character in normal mode
	always_comb begin
		sn_put = 1'b0;
		sn_res = mk_res(K_EOF, ch, 1'b0, 1'b0, 1'b1);
		case (cls)
			CL_TOKEN: begin
				sn_put = 1'b1;
				sn_res = mk_res(token_kind(ch), ch, 1'b0, 1'b0, 1'b1);
			end
			CL_DIGIT: begin
				sn_put = 1'b1;
				sn_res = mk_res(K_NUMBER, ch, 1'b1, 1'b0, 1'b0);
			end
			CL_OTHER: begin
				sn_put = 1'b1;
				sn_res = mk_res(K_UNEXPECTED, ch, 1'b1, 1'b0, 1'b1);
			end
			default: begin
				sn_put = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		op_d   = op_q;
		line_d = line_q;
		err_d  = err_q;
		dot_d  = dot_q;
		if (end_of_input) begin
			mode_d = MODE_NORMAL;
			op_d   = OP_NONE;
			line_d = LINE_WIDTH'(1);
			err_d  = 1'b0;
			dot_d  = 1'b0;
		end else begin
			logic apply_sn;
			apply_sn = 1'b0;
			if (op_q != OP_NONE) begin
				op_d = OP_NONE;
				if (op_q == OP_SLASH && ch == CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else if (!(op_q != OP_SLASH && ch == CH_EQUAL)) begin
					apply_sn = 1'b1;
				end
			end else begin
				case (mode_q)
					MODE_COMMENT: begin
						if (ch == CH_NL) begin
							line_d = line_inc;
							mode_d = MODE_NORMAL;
						end
					end
					MODE_STRING: begin
						if (ch == CH_QUOTE) begin
							mode_d = MODE_NORMAL;
						end else if (ch == CH_NL) begin
							line_d = line_inc;
						end
					end
					MODE_NUMBER: begin
						if (is_digit(ch) || ch == CH_DOT) begin
							if (ch == CH_DOT) begin
								dot_d = 1'b1;
							end
						end else begin
							dot_d    = 1'b0;
							mode_d   = MODE_NORMAL;
							apply_sn = 1'b1;
						end
					end
					default: begin
						apply_sn = 1'b1;
					end
				endcase
			end
			if (apply_sn) begin
				case (cls)
					CL_OPER:    op_d = oper_of(ch);
					CL_NEWLINE: line_d = line_inc;
					CL_QUOTE:   mode_d = MODE_STRING;
					CL_DIGIT: begin
						mode_d = MODE_NUMBER;
						dot_d  = 1'b0;
					end
					CL_OTHER:   err_d = 1'b1;
					default:    ;
				endcase
			end
		end
	end

	// results
	always_comb begin
		n  = 2'd0;
		r0 = sn_res;
		r1 = sn_res;
		if (end_of_input) begin
			r1 = mk_res(K_EOF, ch, 1'b0, 1'b0, 1'b1);
			n  = 2'd2;
			if (op_q != OP_NONE) begin
				r0 = mk_res(single_kind(op_q), ch, 1'b0, 1'b0, 1'b1);
			end else if (mode_q == MODE_NUMBER) begin
				r0 = mk_res(K_NUMBER, ch, 1'b0, dot_q, 1'b1);
			end else if (mode_q == MODE_STRING) begin
				r0 = mk_res(K_UNTERMINATED, ch, 1'b0, 1'b0, 1'b1);
			end else begin
				r0 = r1;
				n  = 2'd1;
			end
		end else if (op_q != OP_NONE) begin
			if (op_q == OP_SLASH && ch == CH_SLASH) begin
				n = 2'd0;
			end else if (op_q != OP_SLASH && ch == CH_EQUAL) begin
				r0 = mk_res(double_kind(op_q), ch, 1'b0, 1'b0, 1'b1);
				n  = 2'd1;
			end else begin
				r0 = mk_res(single_kind(op_q), ch, 1'b0, 1'b0, 1'b1);
				n  = sn_put ? 2'd2 : 2'd1;
			end
		end else begin
			case (mode_q)
				MODE_COMMENT: n = 2'd0;
				MODE_STRING: begin
					n = 2'd1;
					if (ch == CH_QUOTE) begin
						r0 = mk_res(K_STRING, ch, 1'b0, 1'b0, 1'b1);
					end else begin
						r0 = mk_res(K_STRING, ch, 1'b1, 1'b0, 1'b0);
					end
				end
				MODE_NUMBER: begin
					if (is_digit(ch) || ch == CH_DOT) begin
						r0 = mk_res(K_NUMBER, ch, 1'b1, 1'b0, 1'b0);
						n  = 2'd1;
					end else begin
						r0 = mk_res(K_NUMBER, ch, 1'b0, dot_q, 1'b1);
						n  = sn_put ? 2'd2 : 2'd1;
					end
				end
				default: begin
					r0 = sn_res;
					n  = {1'b0, sn_put};
				end
			endcase
		end
	end

	// an error result already carries its own flag, and so does what follows it
	assign err0 = err_q | is_err_kind(r0.kind);
	assign err1 = err0 | is_err_kind(r1.kind);

	always_comb begin
		push            = '0;
		push.n          = acc ? n : 2'd0;
		push.r0         = r0;
		push.r0.line    = line_out;
		push.r0.error_seen = err0;
		push.r1         = r1;
		push.r1.line    = line_out;
		push.r1.error_seen = err1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			op_q   <= OP_NONE;
			line_q <= LINE_WIDTH'(1);
			err_q  <= 1'b0;
			dot_q  <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_d;
			op_q   <= op_d;
			line_q <= line_d;
			err_q  <= err_d;
			dot_q  <= dot_d;
		end
	end

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_input |=> mode_q == MODE_NORMAL && op_q == OP_NONE
			&& line_q == LINE_WIDTH'(1) && !err_q)
		else $error("scanner state not back to start after end of input");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line count wrapped to zero");

	a_op_in_normal: assert property (@(posedge clk) disable iff (!arst_n)
		op_q != OP_NONE |-> mode_q == MODE_NORMAL)
		else $error("pending operator outside normal mode");

	a_eof_two: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_input |-> push.n != 2'd0 && (push.n == 2'd1 ? push.r0.kind == K_EOF
			: push.r1.kind == K_EOF))
		else $error("end of input without an eof result");

endmodule

// ===== rtl/core/lts_out_queue.sv =====
// lts_out_queue: small result queue that takes up to two results a cycle
// and hands out one per beat; also gives the input side its ready
// depends on lts_pkg
module lts_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  lts_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output lts_pkg::res_t  head
);
	import lts_pkg::*;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               pop;
	logic [Q_PTR_W-1:0] wr_nxt;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	// room for the worst case of two results from the next beat
	assign room      = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);
	assign head      = mem_q[rd_q];
	assign wr_nxt    = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_nxt] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_PTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue over-full");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("results pushed without room");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd0 && !pop |=> $stable(cnt_q) && $stable(rd_q))
		else $error("queue count moved with no push or pop");

endmodule
